@@ design/tfm_pkg.sv @@
`default_nettype none

package tfm_pkg;

   // Default size of the pattern store in bytes.
   localparam int PATTERN_BYTES_DEFAULT = 64;

   // Characters with a meaning in a topic filter.
   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] HASH_CHAR  = 8'h23;

   // Command codes of an input transaction.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_TOPIC = 1'b1;

   // What a stored pattern level is.
   typedef enum logic [1:0] {
      KIND_OTHER,
      KIND_PLUS,
      KIND_HASH
   } level_kind_type;

   // How many bytes the pattern level being loaded holds so far.
   typedef enum logic [1:0] {
      FILL_EMPTY,
      FILL_ONE,
      FILL_MANY
   } level_fill_type;

   // Outcome of the topic walk so far.
   typedef enum logic [1:0] {
      VERDICT_UNDECIDED,
      VERDICT_MATCHED,
      VERDICT_FAILED
   } verdict_type;

   // Whether the current topic level still agrees with the pattern level.
   typedef enum logic {
      MODE_COMPARING,
      MODE_MISMATCHED
   } level_mode_type;

   // Input transaction.
   typedef struct packed {
      logic       command;
      logic [7:0] text_byte;
      logic       is_last;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic is_match;
      logic pattern_overflow;
   } rsp_type;

   // Status from the pattern store to the topic walker.
   typedef struct packed {
      logic           overflow;
      level_kind_type last_kind;
      level_kind_type rd_kind;
      logic           rd_next_hash;
      logic [7:0]     cur_byte;
      logic [7:0]     after_byte;
   } level_info_type;

   // Classify a level from its length class and its first byte.
   function automatic level_kind_type level_kind(input level_fill_type fill,
                                                 input logic [7:0] first);
      level_kind_type kind;
      kind = KIND_OTHER;
      if (fill == FILL_ONE && first == PLUS_CHAR) begin
         kind = KIND_PLUS;
      end else if (fill == FILL_ONE && first == HASH_CHAR) begin
         kind = KIND_HASH;
      end
      return kind;
   endfunction

   // Judge one finished topic level against the current pattern level.
   function automatic verdict_type eval_level(input verdict_type verdict,
                                              input logic exhausted,
                                              input logic equal,
                                              input level_kind_type kind);
      verdict_type result;
      result = verdict;
      if (verdict == VERDICT_UNDECIDED) begin
         if (exhausted) begin
            result = VERDICT_FAILED;
         end else if (equal || kind == KIND_PLUS) begin
            result = VERDICT_UNDECIDED;
         end else if (kind == KIND_HASH) begin
            result = VERDICT_MATCHED;
         end else begin
            result = VERDICT_FAILED;
         end
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ design/tfm_pattern_store.sv @@
`default_nettype none

module tfm_pattern_store #(
   parameter int PATTERN_BYTES = tfm_pkg::PATTERN_BYTES_DEFAULT,
   localparam int PosWidth = $clog2(PATTERN_BYTES + 1),
   localparam int IdxWidth = $clog2(PATTERN_BYTES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_en,
   input  logic [7:0]              load_byte,
   input  logic                    load_last,
   input  logic                    topic_en,
   input  logic [PosWidth-1:0]     rd_cursor,
   input  logic [PosWidth-1:0]     rd_level,
   output logic [PosWidth-1:0]     pattern_length,
   output logic [PosWidth-1:0]     last_level,
   output logic [PosWidth-1:0]     rd_next_level,
   output tfm_pkg::level_info_type info
);

   // Pattern bytes, and per level start: its kind, the next level start and
   // whether the level after it is a lone hash.
   logic [7:0]              store_mem [PATTERN_BYTES];
   tfm_pkg::level_kind_type kind_mem  [PATTERN_BYTES];
   logic [PosWidth-1:0]     next_mem  [PATTERN_BYTES];
   logic                    hash_mem  [PATTERN_BYTES];

   // Load-side registers.
   logic [PosWidth-1:0]     len_ff, len_in;
   logic                    ovf_ff, ovf_in;
   logic                    load_new_ff, load_new_in;
   logic                    prev_slash_ff, prev_slash_in;
   logic [PosWidth-1:0]     open_ls_ff, open_ls_in;
   logic [PosWidth-1:0]     prior_ls_ff, prior_ls_in;
   tfm_pkg::level_fill_type fill_ff, fill_in;
   logic [7:0]              first_ff, first_in;

   // Registered read data.
   logic [7:0]              cur_byte_ff;
   logic [7:0]              after_byte_ff;
   tfm_pkg::level_kind_type rd_kind_ff;
   logic [PosWidth-1:0]     rd_next_ff;
   logic                    rd_hash_ff;

   // Working values of the load step.
   logic [PosWidth-1:0]     len_base;
   logic                    ovf_base;
   logic                    prev_slash_base;
   logic [PosWidth-1:0]     open_ls_base;
   tfm_pkg::level_fill_type fill_base;
   logic                    byte_is_slash;
   logic                    keep;
   logic                    room;
   logic                    store_we;
   logic                    level_we;
   logic                    hash_we;
   tfm_pkg::level_kind_type open_kind;
   logic [PosWidth-1:0]     len_step;
   logic [PosWidth-1:0]     rd_after;

   // A new pattern starts from an empty store.
   always_comb begin
      len_base        = load_new_ff ? '0 : len_ff;
      ovf_base        = load_new_ff ? 1'b0 : ovf_ff;
      prev_slash_base = load_new_ff ? 1'b1 : prev_slash_ff;
      open_ls_base    = load_new_ff ? '0 : open_ls_ff;
      fill_base       = load_new_ff ? tfm_pkg::FILL_EMPTY : fill_ff;
      byte_is_slash   = load_byte == tfm_pkg::SLASH_CHAR;
      keep            = !(byte_is_slash && prev_slash_base);
      room            = len_base < PosWidth'(PATTERN_BYTES);
      store_we        = load_en && keep && room;
      level_we        = store_we && byte_is_slash;
      hash_we         = level_we && open_ls_base != '0;
      open_kind       = tfm_pkg::level_kind(fill_base, first_ff);
      len_step        = len_base + PosWidth'(1);
      rd_after        = rd_cursor + PosWidth'(1);
   end

   // Next values of the load-side registers.
   always_comb begin
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      load_new_in   = load_new_ff;
      prev_slash_in = prev_slash_ff;
      open_ls_in    = open_ls_ff;
      prior_ls_in   = prior_ls_ff;
      fill_in       = fill_ff;
      first_in      = first_ff;
      if (load_en) begin
         len_in        = store_we ? len_step : len_base;
         ovf_in        = ovf_base || (keep && !room);
         load_new_in   = load_last;
         prev_slash_in = byte_is_slash;
         open_ls_in    = open_ls_base;
         fill_in       = fill_base;
         if (level_we) begin
            prior_ls_in = open_ls_base;
            open_ls_in  = len_step;
            fill_in     = tfm_pkg::FILL_EMPTY;
         end else if (store_we) begin
            if (fill_base == tfm_pkg::FILL_EMPTY) begin
               first_in = load_byte;
            end
            unique case (fill_base)
               tfm_pkg::FILL_EMPTY: fill_in = tfm_pkg::FILL_ONE;
               tfm_pkg::FILL_ONE:   fill_in = tfm_pkg::FILL_MANY;
               tfm_pkg::FILL_MANY:  fill_in = tfm_pkg::FILL_MANY;
               default:             fill_in = tfm_pkg::FILL_MANY;
            endcase
         end
      end else if (topic_en) begin
         load_new_in = 1'b1;
      end
   end

   // Control registers of the load side.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         ovf_ff        <= 1'b0;
         load_new_ff   <= 1'b1;
         prev_slash_ff <= 1'b1;
         open_ls_ff    <= '0;
         fill_ff       <= tfm_pkg::FILL_EMPTY;
      end else begin
         len_ff        <= len_in;
         ovf_ff        <= ovf_in;
         load_new_ff   <= load_new_in;
         prev_slash_ff <= prev_slash_in;
         open_ls_ff    <= open_ls_in;
         fill_ff       <= fill_in;
      end
   end

   // Payload registers of the load side.
   always_ff @(posedge clock) begin
      prior_ls_ff <= prior_ls_in;
      first_ff    <= first_in;
   end

   // Byte store: one write, two reads; a write to a read address is passed on.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[len_base[IdxWidth-1:0]] <= load_byte;
      end
      cur_byte_ff   <= (store_we && len_base == rd_cursor) ? load_byte
                                                           : store_mem[rd_cursor[IdxWidth-1:0]];
      after_byte_ff <= (store_we && len_base == rd_after) ? load_byte
                                                          : store_mem[rd_after[IdxWidth-1:0]];
   end

   // Level table, written when a slash closes a level.
   always_ff @(posedge clock) begin
      if (level_we) begin
         kind_mem[open_ls_base[IdxWidth-1:0]] <= open_kind;
         next_mem[open_ls_base[IdxWidth-1:0]] <= len_step;
      end
      if (level_we && open_ls_base == rd_level) begin
         rd_kind_ff <= open_kind;
         rd_next_ff <= len_step;
      end else begin
         rd_kind_ff <= kind_mem[rd_level[IdxWidth-1:0]];
         rd_next_ff <= next_mem[rd_level[IdxWidth-1:0]];
      end
   end

   // Lookahead table: the closed level is recorded against the level before it.
   always_ff @(posedge clock) begin
      if (hash_we) begin
         hash_mem[prior_ls_ff[IdxWidth-1:0]] <= open_kind == tfm_pkg::KIND_HASH;
      end
      rd_hash_ff <= (hash_we && prior_ls_ff == rd_level) ? (open_kind == tfm_pkg::KIND_HASH)
                                                         : hash_mem[rd_level[IdxWidth-1:0]];
   end

   assign pattern_length    = len_ff;
   assign last_level        = open_ls_ff;
   assign rd_next_level     = rd_next_ff;
   assign info.overflow     = ovf_ff;
   assign info.last_kind    = tfm_pkg::level_kind(fill_ff, first_ff);
   assign info.rd_kind      = rd_kind_ff;
   assign info.rd_next_hash = rd_hash_ff;
   assign info.cur_byte     = cur_byte_ff;
   assign info.after_byte   = after_byte_ff;

endmodule

`default_nettype wire

@@ design/topic_filter_matcher.sv @@
// Topic filter matcher.
// Input channel req_valid / req_stall / req_data: a transaction with command
// CMD_LOAD appends one byte to the stored filter pattern, one with CMD_TOPIC
// streams one byte of a topic; is_last closes the current string. Leading and
// repeated slashes of the pattern are dropped as it is stored.
// Result channel rsp_valid / rsp_stall / rsp_data: one transaction per topic,
// carrying is_match and pattern_overflow, after its last byte.
// The last topic byte goes from the input register to the result register,
// through the pending step when that byte is a slash that closes a level.
// Throughput: one byte per cycle while the result side does not stall; a topic
// ending in a slash that closes a level takes an extra closing step in which
// req_stall is high. The rate is set by the per-byte compare against the
// registered read of the pattern store. Reset empties the pattern (one empty
// level) and drops any topic in flight; the store contents are not cleared.
// While rsp_stall holds a result, the input register keeps one transaction
// and req_stall rises until the result is taken.
`default_nettype none

module topic_filter_matcher #(
   parameter int PATTERN_BYTES = tfm_pkg::PATTERN_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tfm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tfm_pkg::rsp_type rsp_data
);

   localparam int PosWidth = $clog2(PATTERN_BYTES + 1);

   // Input register.
   logic             in_valid_ff;
   tfm_pkg::req_type in_data_ff;

   // Topic walk state.
   logic                    pend_ff, pend_in;
   logic [PosWidth-1:0]     ls_ff, ls_in;
   logic [PosWidth-1:0]     cur_ff, cur_in;
   tfm_pkg::level_mode_type mode_ff, mode_in;
   tfm_pkg::verdict_type    verdict_ff, verdict_in;
   logic                    exh_ff, exh_in;
   logic                    prev_ff, prev_in;

   // Result register.
   logic             rsp_valid_ff;
   tfm_pkg::rsp_type rsp_data_ff;

   // Pattern store status.
   logic [PosWidth-1:0]     pattern_length;
   logic [PosWidth-1:0]     last_level;
   logic [PosWidth-1:0]     rd_next_level;
   tfm_pkg::level_info_type info;

   // Step decode.
   logic                    out_free;
   logic                    pend_go;
   logic                    item_go;
   logic                    load_en;
   logic                    topic_en;
   logic                    is_slash;
   logic                    level_break;
   logic                    produce;
   logic                    fin_level;
   tfm_pkg::level_kind_type cur_kind;
   logic                    next_hash;
   logic                    eq_here;
   logic                    hit;
   logic [PosWidth-1:0]     cur_step;
   logic                    eq_hit;
   tfm_pkg::verdict_type    verdict_here;
   logic                    adv_exh;
   logic [PosWidth-1:0]     adv_ls;
   logic                    fin_eq;
   tfm_pkg::verdict_type    fin_verdict;
   logic                    fin_match;

   tfm_pattern_store #(
      .PATTERN_BYTES(PATTERN_BYTES)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .load_en       (load_en),
      .load_byte     (in_data_ff.text_byte),
      .load_last     (in_data_ff.is_last),
      .topic_en      (topic_en),
      .rd_cursor     (cur_in),
      .rd_level      (ls_in),
      .pattern_length(pattern_length),
      .last_level    (last_level),
      .rd_next_level (rd_next_level),
      .info          (info)
   );

   // Handshake: a step runs only when the result register can take a result.
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      pend_go   = pend_ff && out_free;
      item_go   = in_valid_ff && !pend_ff && out_free;
      req_stall = in_valid_ff && !item_go;
      load_en   = item_go && in_data_ff.command == tfm_pkg::CMD_LOAD;
      topic_en  = item_go && in_data_ff.command == tfm_pkg::CMD_TOPIC;
   end

   // Level compare and level judgement for the current topic byte.
   always_comb begin
      is_slash     = in_data_ff.text_byte == tfm_pkg::SLASH_CHAR;
      level_break  = is_slash && !prev_ff;
      fin_level    = ls_ff == last_level;
      cur_kind     = fin_level ? info.last_kind : info.rd_kind;
      next_hash    = (rd_next_level == last_level) ? (info.last_kind == tfm_pkg::KIND_HASH)
                                                   : info.rd_next_hash;
      eq_here      = mode_ff == tfm_pkg::MODE_COMPARING &&
                     (cur_ff >= pattern_length || info.cur_byte == tfm_pkg::SLASH_CHAR);
      hit          = mode_ff == tfm_pkg::MODE_COMPARING && cur_ff < pattern_length &&
                     info.cur_byte != tfm_pkg::SLASH_CHAR &&
                     info.cur_byte == in_data_ff.text_byte;
      cur_step     = cur_ff + PosWidth'(1);
      eq_hit       = hit && (cur_step >= pattern_length ||
                             info.after_byte == tfm_pkg::SLASH_CHAR);
      verdict_here = tfm_pkg::eval_level(verdict_ff, exh_ff, eq_here, cur_kind);
      adv_exh      = exh_ff || fin_level;
      adv_ls       = adv_exh ? ls_ff : rd_next_level;
      fin_eq       = (pend_ff || is_slash) ? eq_here : eq_hit;
      fin_verdict  = tfm_pkg::eval_level(verdict_ff, exh_ff, fin_eq, cur_kind);
      fin_match    = fin_verdict == tfm_pkg::VERDICT_MATCHED ||
                     (fin_verdict == tfm_pkg::VERDICT_UNDECIDED && (fin_level || next_hash));
   end

   // Next walk state. A finished or abandoned topic leaves the start state.
   always_comb begin
      ls_in      = ls_ff;
      cur_in     = cur_ff;
      mode_in    = mode_ff;
      verdict_in = verdict_ff;
      exh_in     = exh_ff;
      prev_in    = prev_ff;
      pend_in    = pend_ff;
      produce    = 1'b0;
      if (pend_go) begin
         produce = 1'b1;
         pend_in = 1'b0;
      end else if (topic_en) begin
         if (level_break) begin
            verdict_in = verdict_here;
            exh_in     = adv_exh;
            ls_in      = adv_ls;
            cur_in     = adv_ls;
            mode_in    = tfm_pkg::MODE_COMPARING;
            prev_in    = 1'b1;
            pend_in    = in_data_ff.is_last;
         end else begin
            if (!is_slash) begin
               if (hit) begin
                  cur_in = cur_step;
               end else begin
                  mode_in = tfm_pkg::MODE_MISMATCHED;
               end
               prev_in = 1'b0;
            end
            produce = in_data_ff.is_last;
         end
      end
      if (produce || load_en) begin
         ls_in      = '0;
         cur_in     = '0;
         mode_in    = tfm_pkg::MODE_COMPARING;
         verdict_in = tfm_pkg::VERDICT_UNDECIDED;
         exh_in     = 1'b0;
         prev_in    = 1'b1;
      end
   end

   // Walk state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         ls_ff      <= '0;
         cur_ff     <= '0;
         mode_ff    <= tfm_pkg::MODE_COMPARING;
         verdict_ff <= tfm_pkg::VERDICT_UNDECIDED;
         exh_ff     <= 1'b0;
         prev_ff    <= 1'b1;
      end else begin
         pend_ff    <= pend_in;
         ls_ff      <= ls_in;
         cur_ff     <= cur_in;
         mode_ff    <= mode_in;
         verdict_ff <= verdict_in;
         exh_ff     <= exh_in;
         prev_ff    <= prev_in;
      end
   end

   // Input register takes a transaction whenever it is free or being consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Result register holds its transaction while the receiver stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= produce || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_data_ff.is_match         <= fin_match && !info.overflow;
         rsp_data_ff.pattern_overflow <= info.overflow;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ design/tfm_checker.sv @@
`default_nettype none

module tfm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tfm_pkg::rsp_type rsp_data
);

   // A stalled result transaction stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction changed while stalled");

   // An overflowed pattern never reports a match.
   a_overflow_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_match && rsp_data.pattern_overflow))
      else $error("match reported for an overflowed pattern");

   // Reset leaves both channels empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("channel busy right after reset");

   // With the result side empty, a stall only covers the extra closing step,
   // which delivers a result at once.
   a_stall_delivers: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall && !rsp_valid |=> rsp_valid)
      else $error("input stalled without a result on its way");

endmodule

bind topic_filter_matcher tfm_checker u_tfm_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import tfm_pkg::*;

   localparam int STORE_BYTES  = PATTERN_BYTES_DEFAULT;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TICKS = 6;
   localparam int PHASE_BYTES  = 280;

   // Level shapes used to build filters and topics.
   typedef enum int {
      PICK_A,
      PICK_B,
      PICK_AB,
      PICK_PLUS,
      PICK_HASH,
      PICK_EMPTY,
      PICK_ODD
   } level_pick_type;

   // Tracks the stored filter and the topic walk, and holds the verdicts
   // that are still owed by the block.
   class topic_verdict_board;
      logic [7:0]     filter_mem [STORE_BYTES];
      int unsigned    filter_len;
      bit             filter_overflow;
      bit             filter_restart;
      bit             after_slash;
      int unsigned    cursor;
      int unsigned    level_head;
      bit             filter_done;
      bit             topic_open;
      level_mode_type mode;
      verdict_type    verdict;
      rsp_type        pending_verdicts[$];
      int unsigned    verdict_errors;

      function new();
         foreach (filter_mem[i]) filter_mem[i] = '0;
         filter_len      = 0;
         filter_overflow = 0;
         filter_restart  = 1;
         after_slash     = 1;
         cursor          = 0;
         level_head      = 0;
         filter_done     = 0;
         topic_open      = 0;
         mode            = MODE_COMPARING;
         verdict         = VERDICT_UNDECIDED;
         verdict_errors  = 0;
      endfunction

      // True when the current filter level is exactly the one character.
      function bit level_is_char(logic [7:0] ch);
         if (level_head >= filter_len || filter_mem[level_head] != ch) begin
            return 0;
         end
         return level_head + 1 == filter_len || filter_mem[level_head + 1] == SLASH_CHAR;
      endfunction

      // Settle the verdict once a topic level has been closed.
      function void judge_level();
         bit same;
         if (verdict != VERDICT_UNDECIDED) begin
            return;
         end
         if (filter_done) begin
            verdict = VERDICT_FAILED;
            return;
         end
         same = mode == MODE_COMPARING &&
                (cursor >= filter_len || filter_mem[cursor] == SLASH_CHAR);
         if (same || level_is_char(PLUS_CHAR)) begin
            return;
         end
         verdict = level_is_char(HASH_CHAR) ? VERDICT_MATCHED : VERDICT_FAILED;
      endfunction

      // Move to the start of the next filter level, if there is one.
      function void next_level();
         int unsigned q;
         q = level_head;
         if (!filter_done) begin
            while (q < filter_len && filter_mem[q] != SLASH_CHAR) q++;
            if (q < filter_len) begin
               level_head = q + 1;
            end else begin
               filter_done = 1;
            end
         end
         cursor = level_head;
         mode   = MODE_COMPARING;
      endfunction

      // Apply one accepted input transaction and queue any verdict it owes.
      function void take_request(req_type r);
         rsp_type outcome;
         if (r.command == CMD_LOAD) begin
            topic_open = 0;
            if (filter_restart) begin
               filter_len      = 0;
               filter_overflow = 0;
               after_slash     = 1;
               filter_restart  = 0;
            end
            if (!(r.text_byte == SLASH_CHAR && after_slash)) begin
               if (filter_len < STORE_BYTES) begin
                  filter_mem[filter_len] = r.text_byte;
                  filter_len++;
               end else begin
                  filter_overflow = 1;
               end
               after_slash = r.text_byte == SLASH_CHAR;
            end
            if (r.is_last) begin
               filter_restart = 1;
            end
            return;
         end

         // A topic byte closes any filter load in progress.
         filter_restart = 1;
         if (!topic_open) begin
            topic_open  = 1;
            level_head  = 0;
            cursor      = 0;
            mode        = MODE_COMPARING;
            verdict     = VERDICT_UNDECIDED;
            filter_done = 0;
            after_slash = 1;
         end

         if (r.text_byte == SLASH_CHAR) begin
            if (!after_slash) begin
               judge_level();
               next_level();
               after_slash = 1;
            end
         end else begin
            if (mode == MODE_COMPARING) begin
               if (cursor < filter_len && filter_mem[cursor] != SLASH_CHAR &&
                   filter_mem[cursor] == r.text_byte) begin
                  cursor++;
               end else begin
                  mode = MODE_MISMATCHED;
               end
            end
            after_slash = 0;
         end

         if (!r.is_last) begin
            return;
         end
         judge_level();
         next_level();
         if (verdict == VERDICT_UNDECIDED) begin
            verdict = (filter_done || level_is_char(HASH_CHAR)) ? VERDICT_MATCHED
                                                                : VERDICT_FAILED;
         end
         topic_open               = 0;
         outcome.is_match         = verdict == VERDICT_MATCHED && !filter_overflow;
         outcome.pattern_overflow = filter_overflow;
         pending_verdicts.insert(pending_verdicts.size(), outcome);
      endfunction

      // Compare one result transaction with the oldest owed verdict.
      function void check_verdict(rsp_type got);
         rsp_type want;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result with no verdict owed: is_match %b pattern_overflow %b",
                     $time, got.is_match, got.pattern_overflow);
            verdict_errors++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.is_match !== want.is_match) begin
            $display("%0t: is_match expected %b actual %b",
                     $time, want.is_match, got.is_match);
            verdict_errors++;
         end
         if (got.pattern_overflow !== want.pattern_overflow) begin
            $display("%0t: pattern_overflow expected %b actual %b",
                     $time, want.pattern_overflow, got.pattern_overflow);
            verdict_errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   topic_verdict_board board;
   int                 send_idle_pct;
   int                 stall_pct;
   int                 bytes_sent;
   int                 cycle_count;
   logic [7:0]         text_buf[$];
   level_pick_type     filter_levels[$];

   topic_filter_matcher i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog on the total run length.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("topic_filter_matcher regression: fail");
      $finish;
   end

   // Receiver side: stall at random at the rate of the current phase.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watch both channels; every accepted transaction goes to the board.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.take_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_verdict(rsp_data);
         end
      end
   end

   // Present one transaction, with random sender gaps, until it is accepted.
   task automatic push_item(bit cmd, logic [7:0] ch, bit last);
      req_type item;
      item.command   = cmd;
      item.text_byte = ch;
      item.is_last   = last;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_word(bit cmd, string s, bit last);
      for (int i = 0; i < s.len(); i++) begin
         push_item(cmd, s[i], last && i == s.len() - 1);
      end
   endtask

   task automatic send_text(bit cmd, bit last);
      for (int i = 0; i < text_buf.size(); i++) begin
         push_item(cmd, text_buf[i], last && i == text_buf.size() - 1);
      end
   endtask

   // Append one byte to the text buffer.
   function automatic void add_byte(logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endfunction

   // Stop sending and wait until every owed verdict has come back.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   function automatic level_pick_type any_pick();
      return level_pick_type'($urandom_range(0, 6));
   endfunction

   task automatic put_level(level_pick_type pick);
      logic [7:0] b;
      case (pick)
         PICK_A: begin
            add_byte("a");
         end
         PICK_B: begin
            add_byte("b");
         end
         PICK_AB: begin
            add_byte("a");
            add_byte("b");
         end
         PICK_PLUS: begin
            add_byte(PLUS_CHAR);
         end
         PICK_HASH: begin
            add_byte(HASH_CHAR);
         end
         PICK_ODD: begin
            repeat ($urandom_range(1, 3)) begin
               do b = 8'($urandom_range(255)); while (b == SLASH_CHAR);
               add_byte(b);
            end
         end
         default: begin
         end
      endcase
   endtask

   // Build a filter into the text buffer, now and then one long enough to
   // overflow the store.
   task automatic build_filter();
      int n;
      text_buf.delete();
      filter_levels.delete();
      if ($urandom_range(99) < 4) begin
         filter_levels.insert(filter_levels.size(), PICK_A);
         repeat ($urandom_range(62, 90)) begin
            add_byte(($urandom_range(3) == 0) ? SLASH_CHAR : 8'h61);
         end
         return;
      end
      n = $urandom_range(1, 4);
      repeat (n) filter_levels.insert(filter_levels.size(), any_pick());
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 2)) add_byte(SLASH_CHAR);
      end
      for (int i = 0; i < n; i++) begin
         if (i > 0) begin
            add_byte(SLASH_CHAR);
            if ($urandom_range(99) < 10) add_byte(SLASH_CHAR);
         end
         put_level(filter_levels[i]);
      end
      if ($urandom_range(99) < 15) add_byte(SLASH_CHAR);
      // A filter with no bytes at all goes out as a single slash.
      if (text_buf.size() == 0) add_byte(SLASH_CHAR);
   endtask

   // Build a topic that mostly follows the current filter level by level.
   task automatic build_topic();
      int             stop_at;
      level_pick_type pick;
      text_buf.delete();
      stop_at = filter_levels.size();
      if ($urandom_range(99) < 20) stop_at = $urandom_range(0, stop_at - 1);
      if ($urandom_range(99) < 10) add_byte(SLASH_CHAR);
      for (int i = 0; i < stop_at; i++) begin
         if (i > 0) begin
            add_byte(SLASH_CHAR);
            if ($urandom_range(99) < 8) add_byte(SLASH_CHAR);
         end
         pick = filter_levels[i];
         if (pick == PICK_PLUS || pick == PICK_HASH || $urandom_range(99) < 20) begin
            pick = any_pick();
         end
         put_level(pick);
      end
      if ($urandom_range(99) < 20) begin
         add_byte(SLASH_CHAR);
         put_level(any_pick());
      end
      if ($urandom_range(99) < 15) add_byte(SLASH_CHAR);
      if (text_buf.size() == 0) add_byte("a");
   endtask

   // One random sequence: mostly a filter followed by topics, sometimes
   // strings cut short, sometimes raw noise.
   task automatic run_sequence();
      int r;
      r = $urandom_range(99);
      if (r < 80) begin
         build_filter();
         send_text(CMD_LOAD, 1'b1);
         repeat ($urandom_range(1, 4)) begin
            build_topic();
            send_text(CMD_TOPIC, 1'b1);
         end
      end else if (r < 90) begin
         build_filter();
         send_text(CMD_LOAD, 1'($urandom_range(1)));
         build_topic();
         send_text(CMD_TOPIC, 1'($urandom_range(1)));
      end else begin
         repeat ($urandom_range(1, 12)) begin
            push_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                      $urandom_range(99) < 25);
         end
      end
   endtask

   initial begin
      req_valid     = 1'b0;
      req_data      = '0;
      reset         = 1'b1;
      send_idle_pct = 0;
      stall_pct     = 0;
      bytes_sent    = 0;
      board         = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Topics before any filter see one empty level.
      send_word(CMD_TOPIC, "/", 1'b1);
      send_word(CMD_TOPIC, "a", 1'b1);
      // Leading slashes dropped; a hash level takes the whole topic.
      send_word(CMD_LOAD, "//#", 1'b1);
      send_word(CMD_TOPIC, "x/y", 1'b1);
      // Plus level and a final empty level after a trailing slash.
      send_word(CMD_LOAD, "a/+/", 1'b1);
      send_word(CMD_TOPIC, "a/q/", 1'b1);
      // Extreme byte values in both strings.
      push_item(CMD_LOAD, 8'h00, 1'b0);
      push_item(CMD_LOAD, 8'hFF, 1'b1);
      push_item(CMD_TOPIC, 8'h00, 1'b0);
      push_item(CMD_TOPIC, 8'hFF, 1'b1);
      // A load left open is closed by a topic; filter longer than topic.
      send_word(CMD_LOAD, "a/b", 1'b0);
      send_word(CMD_TOPIC, "a", 1'b1);
      // An open topic is abandoned by a filter byte.
      send_word(CMD_TOPIC, "a/", 1'b0);
      send_word(CMD_LOAD, "a/#", 1'b1);
      // Filter longer than topic with a hash level next.
      send_word(CMD_TOPIC, "a", 1'b1);
      send_word(CMD_TOPIC, "a/b/c", 1'b1);
      settle();

      // Random phases with different idling on each side.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 74;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 74;
            end
            default: begin
               send_idle_pct = 14;
               stall_pct     = 14;
            end
         endcase
         while (bytes_sent < 30 + (phase + 1) * PHASE_BYTES) run_sequence();
         settle();
      end

      if (board.verdict_errors == 0 && board.pending_verdicts.size() == 0) begin
         $display("topic_filter_matcher regression: pass");
      end else begin
         $display("topic_filter_matcher regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/tfm_pkg.sv
design/tfm_pattern_store.sv
design/topic_filter_matcher.sv
design/tfm_checker.sv
tb/tb.sv
